// ===== rtl/northwest_corner_transport_macros.svh =====
// Assertion macros for the northwest-corner transport block
`ifndef NORTHWEST_CORNER_TRANSPORT_MACROS_SVH
`define NORTHWEST_CORNER_TRANSPORT_MACROS_SVH

// check a property on every clock edge outside reset
`define NWCT_CHECK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property on every clock edge, reset included
`define NWCT_CHECK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/nwct_pkg.sv =====
// Package: widths, codes and state encoding for the northwest-corner transport block
`timescale 1ns / 1ps

package nwct_pkg;

    localparam int MAX_SOURCES = 4;
    localparam int MAX_DESTS   = 4;
    localparam int VALUE_WIDTH = 16;

    localparam int REQ_W    = 2;
    localparam int ROW_W    = 2;
    localparam int COL_W    = 2;
    localparam int IN_VAL_W = 16;
    localparam int COST_W   = 48;
    localparam int STAT_W   = 2;
    localparam int CNT_W    = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    localparam int MAX_N      = (MAX_SOURCES > MAX_DESTS) ? MAX_SOURCES : MAX_DESTS;
    localparam int SRC_IW     = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int DST_IW     = (MAX_DESTS > 1) ? $clog2(MAX_DESTS) : 1;
    localparam int COST_DEPTH = MAX_SOURCES * MAX_DESTS;
    localparam int COST_AW    = (COST_DEPTH > 1) ? $clog2(COST_DEPTH) : 1;
    localparam int IDX_W      = $clog2(MAX_N + 1);
    localparam int SUM_W      = VALUE_WIDTH + $clog2(MAX_N + 1);
    localparam int PROD_W     = 2 * VALUE_WIDTH;

    typedef enum logic [REQ_W-1:0] {
        REQ_SUPPLY = 2'd0,
        REQ_DEMAND = 2'd1,
        REQ_COST   = 2'd2,
        REQ_SOLVE  = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_UNBAL    = 2'd1,
        STAT_LEFTOVER = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_SOURCES = 1'd0,
        CFG_NUM_DESTS   = 1'd1
    } t_cfg_idx;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SUM    = 8'b0000_0010,
        ST_CHECK  = 8'b0000_0100,
        ST_WALK_A = 8'b0000_1000,
        ST_WALK_B = 8'b0001_0000,
        ST_WALK_C = 8'b0010_0000,
        ST_LEFT   = 8'b0100_0000,
        ST_OUT    = 8'b1000_0000
    } t_state;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                     input logic [CNT_W-1:0] max_v);
        logic [CNT_W-1:0] res;
        if (v == '0) begin
            res = CNT_W'(1);
        end else if (v > max_v) begin
            res = max_v;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// ===== rtl/nwct_if.sv =====
// Channel interfaces: request items in, result items out
`timescale 1ns / 1ps

interface nwct_req_if;
    import nwct_pkg::*;

    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [IN_VAL_W-1:0] value;

    modport source (output valid, req_type, row, col, value, input ready);
    modport sink   (input valid, req_type, row, col, value, output ready);
endinterface

interface nwct_res_if;
    import nwct_pkg::*;

    logic              valid;
    logic              ready;
    logic [COST_W-1:0] total_cost;
    logic [STAT_W-1:0] status;

    modport source (output valid, total_cost, status, input ready);
    modport sink   (input valid, total_cost, status, output ready);
endinterface

// ===== rtl/northwest_corner_transport.sv =====
// Top level: northwest-corner transportation solver with cost memory and walk sequencer
`timescale 1ns / 1ps
`include "northwest_corner_transport_macros.svh"
//
// Request items arrive on i_req (valid/ready). Load supply, load demand and
// load cost items write the stores in the cycle they are accepted and give
// no result; one load item is taken per cycle while no solve is in flight.
// A solve item gives exactly one item on o_res: total cost and status (ok,
// unbalanced, leftover). A solve runs in a sequencer around one unit-cost
// memory with a registered read: it sums and copies the vectors, compares
// totals, then walks at most ns + nd - 1 shipped cells, each read, multiplied
// and accumulated, and scans for leftovers before it loads the output register.
// An unbalanced solve skips the walk and the leftover scan. i_req.ready is
// high only while no solve is in flight.
// The result sits in an output register; loads are still taken while it
// waits. A solve that finishes while the receiver stalls holds until the
// output register frees.
// Reset (i_rst_n low, synchronous) sets num_sources to 3, num_dests to 4,
// clears the sequencer and drops any pending result; stores keep old data.
// Configuration (i_cfg_we, i_cfg_idx, i_cfg_data) must be written by the user
// only while idle; the block itself does not enforce this.
module northwest_corner_transport (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [nwct_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [nwct_pkg::CFG_DATA_W-1:0] i_cfg_data,
    nwct_req_if.sink                        i_req,
    nwct_res_if.source                      o_res
);
    import nwct_pkg::*;

    logic [VALUE_WIDTH-1:0] supply_store [MAX_SOURCES];
    logic [VALUE_WIDTH-1:0] demand_store [MAX_DESTS];
    logic [VALUE_WIDTH-1:0] cost_mem     [COST_DEPTH];

    t_state                 r_state,     n_state;
    logic [CNT_W-1:0]       r_num_src,   n_num_src;
    logic [CNT_W-1:0]       r_num_dst,   n_num_dst;
    logic [IDX_W-1:0]       r_idx,       n_idx;
    logic [SUM_W-1:0]       r_sum_s,     n_sum_s;
    logic [SUM_W-1:0]       r_sum_d,     n_sum_d;
    logic [VALUE_WIDTH-1:0] r_sup_w [MAX_SOURCES];
    logic [VALUE_WIDTH-1:0] n_sup_w [MAX_SOURCES];
    logic [VALUE_WIDTH-1:0] r_dem_w [MAX_DESTS];
    logic [VALUE_WIDTH-1:0] n_dem_w [MAX_DESTS];
    logic [CNT_W-1:0]       r_row_ptr,   n_row_ptr;
    logic [CNT_W-1:0]       r_col_ptr,   n_col_ptr;
    logic [COST_W-1:0]      r_acc,       n_acc;
    logic [PROD_W-1:0]      r_prod,      n_prod;
    logic                   r_left,      n_left;
    logic [COST_W-1:0]      r_res_cost,  n_res_cost;
    t_status                r_res_stat,  n_res_stat;
    logic                   r_out_valid, n_out_valid;
    logic [COST_W-1:0]      r_out_cost,  n_out_cost;
    t_status                r_out_stat,  n_out_stat;
    logic [VALUE_WIDTH-1:0] r_cost_rd;

    logic [CNT_W-1:0]       w_ns;
    logic [CNT_W-1:0]       w_nd;
    logic [IDX_W-1:0]       w_scan_last;
    logic                   w_accept;
    logic [VALUE_WIDTH-1:0] w_val;
    logic [COST_AW-1:0]     w_wr_addr;
    logic [COST_AW-1:0]     w_rd_addr;
    logic [SRC_IW-1:0]      w_row_i;
    logic [DST_IW-1:0]      w_col_i;
    logic [VALUE_WIDTH-1:0] w_s;
    logic [VALUE_WIDTH-1:0] w_d;
    logic [VALUE_WIDTH-1:0] w_t;
    logic                   w_out_free;
    logic                   w_hit;

    assign w_ns = clamp_count(r_num_src, CNT_W'(MAX_SOURCES));
    assign w_nd = clamp_count(r_num_dst, CNT_W'(MAX_DESTS));
    assign w_scan_last = (w_ns > w_nd) ? IDX_W'(w_ns - CNT_W'(1))
                                       : IDX_W'(w_nd - CNT_W'(1));

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_val       = VALUE_WIDTH'(i_req.value);
    assign w_wr_addr   = COST_AW'(32'(i_req.row) * MAX_DESTS + 32'(i_req.col));

    assign w_row_i   = SRC_IW'(r_row_ptr);
    assign w_col_i   = DST_IW'(r_col_ptr);
    assign w_rd_addr = COST_AW'(32'(w_row_i) * MAX_DESTS + 32'(w_col_i));
    assign w_s       = r_sup_w[w_row_i];
    assign w_d       = r_dem_w[w_col_i];
    assign w_t       = (w_s < w_d) ? w_s : w_d;

    assign w_out_free = !r_out_valid || o_res.ready;

    assign o_res.valid      = r_out_valid;
    assign o_res.total_cost = r_out_cost;
    assign o_res.status     = r_out_stat;

    always_ff @(posedge i_clk) begin
        if (w_accept && (t_req'(i_req.req_type) == REQ_SUPPLY)
                && (32'(i_req.row) < MAX_SOURCES)) begin
            supply_store[SRC_IW'(i_req.row)] <= w_val;
        end
        if (w_accept && (t_req'(i_req.req_type) == REQ_DEMAND)
                && (32'(i_req.col) < MAX_DESTS)) begin
            demand_store[DST_IW'(i_req.col)] <= w_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (t_req'(i_req.req_type) == REQ_COST)
                && (32'(i_req.row) < MAX_SOURCES) && (32'(i_req.col) < MAX_DESTS)) begin
            cost_mem[w_wr_addr] <= w_val;
        end
        r_cost_rd <= cost_mem[w_rd_addr];
    end

    always_comb begin
        n_state     = r_state;
        n_num_src   = r_num_src;
        n_num_dst   = r_num_dst;
        n_idx       = r_idx;
        n_sum_s     = r_sum_s;
        n_sum_d     = r_sum_d;
        n_sup_w     = r_sup_w;
        n_dem_w     = r_dem_w;
        n_row_ptr   = r_row_ptr;
        n_col_ptr   = r_col_ptr;
        n_acc       = r_acc;
        n_prod      = r_prod;
        n_left      = r_left;
        n_res_cost  = r_res_cost;
        n_res_stat  = r_res_stat;
        n_out_valid = r_out_valid;
        n_out_cost  = r_out_cost;
        n_out_stat  = r_out_stat;
        w_hit       = 1'b0;

        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_NUM_SOURCES: n_num_src = CNT_W'(i_cfg_data);
                CFG_NUM_DESTS:   n_num_dst = CNT_W'(i_cfg_data);
                default: ;
            endcase
        end

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (t_req'(i_req.req_type) == REQ_SOLVE)) begin
                    n_idx   = '0;
                    n_sum_s = '0;
                    n_sum_d = '0;
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (CNT_W'(r_idx) < w_ns) begin
                    n_sup_w[SRC_IW'(r_idx)] = supply_store[SRC_IW'(r_idx)];
                    n_sum_s = r_sum_s + SUM_W'(supply_store[SRC_IW'(r_idx)]);
                end
                if (CNT_W'(r_idx) < w_nd) begin
                    n_dem_w[DST_IW'(r_idx)] = demand_store[DST_IW'(r_idx)];
                    n_sum_d = r_sum_d + SUM_W'(demand_store[DST_IW'(r_idx)]);
                end
                n_idx = r_idx + IDX_W'(1);
                if (r_idx == w_scan_last) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_sum_s != r_sum_d) begin
                    n_res_cost = '0;
                    n_res_stat = STAT_UNBAL;
                    n_state    = ST_OUT;
                end else begin
                    n_row_ptr = '0;
                    n_col_ptr = '0;
                    n_acc     = '0;
                    n_state   = ST_WALK_A;
                end
            end
            ST_WALK_A: begin
                if ((r_row_ptr >= w_ns) || (r_col_ptr >= w_nd)) begin
                    n_idx   = '0;
                    n_left  = 1'b0;
                    n_state = ST_LEFT;
                end else if (w_d == '0) begin
                    n_col_ptr = r_col_ptr + CNT_W'(1);
                end else if (w_s == '0) begin
                    n_row_ptr = r_row_ptr + CNT_W'(1);
                end else begin
                    n_state = ST_WALK_B;
                end
            end
            ST_WALK_B: begin
                n_sup_w[w_row_i] = w_s - w_t;
                n_dem_w[w_col_i] = w_d - w_t;
                n_prod  = PROD_W'(r_cost_rd) * PROD_W'(w_t);
                n_state = ST_WALK_C;
            end
            ST_WALK_C: begin
                n_acc   = r_acc + COST_W'(r_prod);
                n_state = ST_WALK_A;
            end
            ST_LEFT: begin
                if ((CNT_W'(r_idx) < w_ns) && (r_sup_w[SRC_IW'(r_idx)] != '0)) begin
                    w_hit = 1'b1;
                end
                if ((CNT_W'(r_idx) < w_nd) && (r_dem_w[DST_IW'(r_idx)] != '0)) begin
                    w_hit = 1'b1;
                end
                n_left = r_left || w_hit;
                n_idx  = r_idx + IDX_W'(1);
                if (r_idx == w_scan_last) begin
                    n_res_cost = n_left ? '0 : r_acc;
                    n_res_stat = n_left ? STAT_LEFTOVER : STAT_OK;
                    n_state    = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_cost  = r_res_cost;
                    n_out_stat  = r_res_stat;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_num_src   <= CNT_W'(3);
            r_num_dst   <= CNT_W'(4);
            r_idx       <= '0;
            r_row_ptr   <= '0;
            r_col_ptr   <= '0;
            r_acc       <= '0;
            r_left      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_num_src   <= n_num_src;
            r_num_dst   <= n_num_dst;
            r_idx       <= n_idx;
            r_row_ptr   <= n_row_ptr;
            r_col_ptr   <= n_col_ptr;
            r_acc       <= n_acc;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
        r_sum_s    <= n_sum_s;
        r_sum_d    <= n_sum_d;
        r_sup_w    <= n_sup_w;
        r_dem_w    <= n_dem_w;
        r_prod     <= n_prod;
        r_res_cost <= n_res_cost;
        r_res_stat <= n_res_stat;
        r_out_cost <= n_out_cost;
        r_out_stat <= n_out_stat;
    end

    `NWCT_CHECK(a_walk_in_range, i_clk, i_rst_n,
        (r_state == ST_WALK_B) |-> ((r_row_ptr < w_ns) && (r_col_ptr < w_nd)),
        "walk cell outside configured range")

    `NWCT_CHECK(a_fail_zero_cost, i_clk, i_rst_n,
        (o_res.valid && (o_res.status != STAT_OK)) |-> (o_res.total_cost == '0),
        "failed solve carries nonzero cost")

    `NWCT_CHECK(a_solve_starts, i_clk, i_rst_n,
        (w_accept && (i_req.req_type == REQ_SOLVE)) |=> (r_state == ST_SUM),
        "accepted solve did not start summing")

    `NWCT_CHECK_ALWAYS(a_rst_idle, i_clk,
        !i_rst_n |=> ((r_state == ST_IDLE) && !r_out_valid),
        "reset did not return to idle")

endmodule
